/* hdl/fgn_pkg.sv */
// Package for the fractal gradient noise core: constants, config defaults,
// the seed premix and the corner hash function. No dependencies.
package fgn_pkg;
	localparam int MAX_OCTAVES_DEF = 8;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int FREQ_FRAC       = 8;
	localparam int OUT_W           = 19;
	localparam int CFG_W           = 32;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE = 2'd2;

	localparam logic [15:0] FREQ_RST   = 16'd256;
	localparam logic [31:0] SEED_RST   = 32'd0;
	localparam logic [3:0]  OCTAVE_RST = 4'd4;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;

	// premix of the seed, independent of the corner
	function automatic logic [31:0] seed_mix(input logic [31:0] s);
		logic [31:0] h;
		h = s;
		h = h ^ (h << 13);
		h = h ^ (h >> 7);
		h = h ^ (h << 17);
		return h;
	endfunction

	// remainder of the corner hash after the seed mix
	function automatic logic [31:0] corner_hash(input logic [31:0] hs,
			input logic [31:0] cx, input logic [31:0] cy);
		logic [31:0] h;
		h = hs ^ cy;
		h = h ^ (h << 5);
		h = h ^ (h >> 2);
		h = h ^ (h << 3);
		h = h ^ cx;
		return h;
	endfunction
endpackage

/* hdl/fgn_octave.sv */
// One octave of 2D gradient noise as a five-stage pipeline.
// Depends on fgn_pkg.
module fgn_octave import fgn_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int OCT       = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vin,
	input  logic [31:0]              px,
	input  logic [31:0]              py,
	input  logic [15:0]              freq,
	input  logic [31:0]              seed_h,
	output logic                     vout,
	output logic signed [FRAC_BITS+2:0] noise
);
	localparam int F  = FRAC_BITS;
	localparam int DW = F + 3;
	localparam int SH = 16 + FREQ_FRAC;
	localparam int PW = SH + 32;
	localparam logic [F+1:0] ONE3 = (F+2)'(3) << F;

	logic [4:0] v;
	assign vout = v[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v <= '0;
		else v <= {v[3:0], vin};
	end

	// stage 1: scale coordinates
	logic signed [48:0] sx_s1, sy_s1;
	always_ff @(posedge clk) begin
		sx_s1 <= $signed(px) * $signed({1'b0, freq});
		sy_s1 <= $signed(py) * $signed({1'b0, freq});
	end

	// sign-extended product, shifted by the octave; bits above the cell wrap off
	logic [PW-1:0] qx, qy;
	assign qx = PW'(sx_s1) << OCT;
	assign qy = PW'(sy_s1) << OCT;

	// stage 2: cell, fraction, hashes, t*t
	logic [31:0] cx_w, cy_w;
	logic [F-1:0] fx_w, fy_w;
	assign cx_w = qx[SH +: 32];
	assign cy_w = qy[SH +: 32];
	assign fx_w = qx[SH-F +: F];
	assign fy_w = qy[SH-F +: F];

	logic [31:0] h_w [4];
	assign h_w[0] = corner_hash(seed_h, cx_w, cy_w);
	assign h_w[1] = corner_hash(seed_h, cx_w + 32'd1, cy_w);
	assign h_w[2] = corner_hash(seed_h, cx_w, cy_w + 32'd1);
	assign h_w[3] = corner_hash(seed_h, cx_w + 32'd1, cy_w + 32'd1);

	logic [2:0] g_s2 [4];
	logic [F-1:0] fx_s2, fy_s2;
	logic [F-1:0] tx_s2, ty_s2;
	always_ff @(posedge clk) begin
		g_s2[0] <= h_w[0][2:0];
		g_s2[1] <= h_w[1][2:0];
		g_s2[2] <= h_w[2][2:0];
		g_s2[3] <= h_w[3][2:0];
		fx_s2 <= fx_w;
		fy_s2 <= fy_w;
		tx_s2 <= F'((2*F)'(fx_w) * (2*F)'(fx_w) >> F);
		ty_s2 <= F'((2*F)'(fy_w) * (2*F)'(fy_w) >> F);
	end

	// gradient dot with the corner offset
	function automatic logic signed [DW-1:0] gdot(input logic [2:0] k,
			input logic signed [DW-1:0] ox, input logic signed [DW-1:0] oy);
		logic signed [DW-1:0] r;
		case (k)
			3'd0: r = ox + oy;
			3'd1: r = oy - ox;
			3'd2: r = ox - oy;
			3'd3: r = -ox - oy;
			3'd4: r = ox;
			3'd5: r = -ox;
			3'd6: r = oy;
			default: r = -oy;
		endcase
		return r;
	endfunction

	// stage 3: dots and smoothstep weights
	logic signed [DW-1:0] ax, ay, bx, by;
	assign ax = DW'(fx_s2);
	assign ay = DW'(fy_s2);
	assign bx = ax - (DW'(1) << F);
	assign by = ay - (DW'(1) << F);

	logic signed [DW-1:0] n_s3 [4];
	logic [F+1:0] u_s3, w_s3;
	always_ff @(posedge clk) begin
		n_s3[0] <= gdot(g_s2[0], ax, ay);
		n_s3[1] <= gdot(g_s2[1], bx, ay);
		n_s3[2] <= gdot(g_s2[2], ax, by);
		n_s3[3] <= gdot(g_s2[3], bx, by);
		u_s3 <= (F+2)'(((2*F+2)'(tx_s2) * (2*F+2)'(ONE3 - ((F+2)'(fx_s2) << 1))) >> F);
		w_s3 <= (F+2)'(((2*F+2)'(ty_s2) * (2*F+2)'(ONE3 - ((F+2)'(fy_s2) << 1))) >> F);
	end

	// stage 4: blend along x
	localparam int MW = DW + F + 4;
	logic signed [MW-1:0] m0, m1;
	assign m0 = MW'(n_s3[1] - n_s3[0]) * $signed({1'b0, u_s3});
	assign m1 = MW'(n_s3[3] - n_s3[2]) * $signed({1'b0, u_s3});

	logic signed [DW-1:0] l0_s4, l1_s4;
	logic [F+1:0] w_s4;
	always_ff @(posedge clk) begin
		l0_s4 <= n_s3[0] + DW'(m0 >>> F);
		l1_s4 <= n_s3[2] + DW'(m1 >>> F);
		w_s4  <= w_s3;
	end

	// stage 5: blend along y
	logic signed [MW-1:0] m2;
	assign m2 = MW'(l1_s4 - l0_s4) * $signed({1'b0, w_s4});
	always_ff @(posedge clk) begin
		noise <= l0_s4 + DW'(m2 >>> F);
	end
endmodule

/* hdl/fractal_gradient_noise_2d_core.sv */
// Fractal 2D gradient noise core: each start yields a done strobe,
// one item accepted every cycle (busy stays low); all octaves run in
// parallel lanes of five stages, then one sum and one saturate stage.
// Reset: registers back to frequency 1.0, seed 0, four octaves; the
// pipeline valid bits clear. Results cannot be stalled by the receiver.
// Depends on fgn_pkg and fgn_octave.
module fractal_gradient_noise_2d_core import fgn_pkg::*; #(
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [31:0]      point_x,
	input  logic signed [31:0]      point_y,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    done,
	output logic signed [OUT_W-1:0] terrain_value
);
	localparam int DW = FRAC_BITS + 3;
	localparam int SW = DW + 6;

	logic [15:0] freq_q;
	logic [31:0] seed_q, seed_h_q;
	logic [3:0]  oct_q;

	assign busy = 1'b0;

	// configuration registers; the seed premix is kept registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q   <= FREQ_RST;
			seed_q   <= SEED_RST;
			seed_h_q <= seed_mix(SEED_RST);
			oct_q    <= OCTAVE_RST;
		end else begin
			seed_h_q <= seed_mix(seed_q);
			if (cfg_we) begin
				case (cfg_index)
					REG_FREQ:   freq_q <= cfg_data[15:0];
					REG_SEED:   seed_q <= cfg_data;
					REG_OCTAVE: oct_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

	logic [MAX_OCTAVES-1:0] lv;
	logic signed [DW-1:0] ln [MAX_OCTAVES];

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		fgn_octave #(.FRAC_BITS(FRAC_BITS), .OCT(i)) u_oct (
			.clk(clk), .arst_n(arst_n), .vin(start),
			.px(point_x), .py(point_y), .freq(freq_q), .seed_h(seed_h_q),
			.vout(lv[i]), .noise(ln[i])
		);
	end

	// weighted sum of enabled octaves
	logic signed [SW-1:0] sum_c;
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < MAX_OCTAVES; i++)
			if (5'(i) < {1'b0, oct_q}) sum_c = sum_c + SW'(ln[i] >>> i);
	end

	logic v_s6;
	logic signed [SW-1:0] sum_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= lv[0];
	end
	always_ff @(posedge clk) sum_s6 <= sum_c;

	// rescale to 16 fraction bits and saturate
	localparam int RW = SW + 16;
	logic signed [RW-1:0] r;
	always_comb begin
		if (FRAC_BITS >= 16) r = RW'(sum_s6 >>> (FRAC_BITS - 16));
		else r = RW'(sum_s6) <<< (16 - FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (r > RW'(OUT_MAX)) terrain_value <= OUT_MAX;
		else if (r < RW'(OUT_MIN)) terrain_value <= OUT_MIN;
		else terrain_value <= OUT_W'(r);
	end
endmodule
